### design/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, disabled while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/tlrg_pkg.sv
// Shared constants and controller/datapath interface types for the ramp generator.
package tlrg_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned DIV_STEPS  = 7;
    localparam int unsigned DIV_IDX_W  = 3;
    localparam int unsigned REM_W      = TIME_W + PCT_W;
    localparam int unsigned MAG_W      = LEVEL_W + PCT_W;
    localparam int unsigned RECIP_W    = 13;
    localparam int unsigned RECIP_SH   = 19;

    localparam logic [PCT_W-1:0]     PCT_FULL  = 7'd100;
    // floor(m/100) == (m*5243) >> 19 for every m up to 255*100
    localparam logic [RECIP_W-1:0]   RECIP_100 = 13'd5243;
    localparam logic [DIV_IDX_W-1:0] DIV_TOP   = 3'(DIV_STEPS - 1);

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_START_LEVEL = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_LEVEL   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DURATION    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_TIME  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLINK       = 3'd4;

    typedef struct packed {
        logic                 load;     // capture timestamp, form elapsed time
        logic                 prep;     // form elapsed*100, saturation flag
        logic                 div;      // one restoring divide step
        logic [DIV_IDX_W-1:0] div_idx;  // quotient bit of this step
        logic                 scale;    // |end-start| * percent
        logic                 recip;    // divide by 100 via reciprocal
        logic                 finish;   // write result, update blink state
    } t_cmd;

    typedef struct packed {
        logic sat;  // elapsed time reached the duration: percent is 100
    } t_sts;

endpackage

### design/tlrg_ctrl.sv
// Sequencing state machine of the ramp generator.
module tlrg_ctrl
    import tlrg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_SCALE,
        S_RECIP,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [DIV_IDX_W-1:0] r_cnt;
    logic                 r_in_ready;
    logic                 r_out_valid;
    logic                 w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_idx = r_cnt;
        unique case (r_state)
            S_IDLE:  o_cmd.load   = i_in_valid;
            S_PREP:  o_cmd.prep   = 1'b1;
            S_DIV:   o_cmd.div    = !i_sts.sat;
            S_SCALE: o_cmd.scale  = 1'b1;
            S_RECIP: o_cmd.recip  = 1'b1;
            S_DONE:  o_cmd.finish = w_out_free;
            default: o_cmd        = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // present a new result, or drop the one just taken
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in_ready <= 1'b0;
                        r_state    <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cnt   <= DIV_TOP;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // saturated percent needs no quotient
                    if (i_sts.sat || r_cnt == '0) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SCALE: r_state <= S_RECIP;
                S_RECIP: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### design/tlrg_dp.sv
// Datapath of the ramp generator: registers, divider, scaling and level output.
module tlrg_dp
    import tlrg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [TIME_W-1:0]     i_now_time,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [LEVEL_W-1:0]    o_level,
    output logic                  o_ramp_enabled
);

    // configuration and ramp state
    logic signed [LEVEL_W-1:0] r_start;
    logic signed [LEVEL_W-1:0] r_end;
    logic [TIME_W-1:0]         r_dur;
    logic                      r_blink;
    logic [TIME_W-1:0]         r_origin;
    logic                      r_rev;

    // per-transaction working registers
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_elapsed;
    logic [REM_W-1:0]   r_rem;
    logic [PCT_W-1:0]   r_q;
    logic               r_sat;
    logic [MAG_W-1:0]   r_mag;
    logic               r_neg;
    logic [LEVEL_W-1:0] r_step;
    logic [LEVEL_W-1:0] r_level;
    logic               r_ramp_en;

    logic [TIME_W-1:0]            w_dur;
    logic [REM_W-1:0]             w_x100;
    logic [REM_W-1:0]             w_trial;
    logic [PCT_W-1:0]             w_pct;
    logic signed [LEVEL_W:0]      w_diff;
    logic [LEVEL_W-1:0]           w_absd;
    logic [MAG_W+RECIP_W-1:0]     w_recip;
    logic signed [LEVEL_W:0]      w_step;
    logic signed [LEVEL_W+1:0]    w_lvl;

    assign w_dur   = (r_dur == '0) ? TIME_W'(1) : r_dur;
    assign w_x100  = ({{PCT_W{1'b0}}, r_elapsed} << 6) + ({{PCT_W{1'b0}}, r_elapsed} << 5)
                   + ({{PCT_W{1'b0}}, r_elapsed} << 2);
    assign w_trial = {{PCT_W{1'b0}}, w_dur} << i_cmd.div_idx;
    assign w_pct   = r_sat ? PCT_FULL : r_q;
    assign w_diff  = {r_end[LEVEL_W-1], r_end} - {r_start[LEVEL_W-1], r_start};
    assign w_absd  = w_diff[LEVEL_W] ? LEVEL_W'(-w_diff) : w_diff[LEVEL_W-1:0];
    assign w_recip = {{RECIP_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, RECIP_100};
    assign w_step  = r_neg ? -$signed({1'b0, r_step}) : $signed({1'b0, r_step});
    assign w_lvl   = r_rev ? ({{2{r_end[LEVEL_W-1]}}, r_end} - {w_step[LEVEL_W], w_step})
                           : ({{2{r_start[LEVEL_W-1]}}, r_start} + {w_step[LEVEL_W], w_step});

    // configuration, origin and direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_end    <= '0;
            r_dur    <= TIME_W'(1);
            r_blink  <= 1'b0;
            r_origin <= '0;
            r_rev    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_LEVEL: r_start <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_END_LEVEL:   r_end   <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_DURATION:    r_dur   <= i_cfg_wdata[TIME_W-1:0];
                CFG_START_TIME: begin
                    r_origin <= i_cfg_wdata[TIME_W-1:0];
                    r_rev    <= 1'b0;
                end
                CFG_BLINK:       r_blink <= i_cfg_wdata[0];
                default: ;
            endcase
        end else if (i_cmd.finish && r_blink && r_sat) begin
            // turn around at the far end
            r_rev    <= ~r_rev;
            r_origin <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now     <= i_now_time;
            r_elapsed <= i_now_time - r_origin;
        end
        if (i_cmd.prep) begin
            r_rem <= w_x100;
            r_sat <= r_elapsed >= w_dur;
            r_q   <= '0;
        end
        if (i_cmd.div && r_rem >= w_trial) begin
            r_rem             <= r_rem - w_trial;
            r_q[i_cmd.div_idx] <= 1'b1;
        end
        if (i_cmd.scale) begin
            r_mag <= MAG_W'(w_absd) * MAG_W'(w_pct);
            r_neg <= w_diff[LEVEL_W];
        end
        if (i_cmd.recip) begin
            r_step <= w_recip[RECIP_SH+LEVEL_W-1:RECIP_SH];
        end
        if (i_cmd.finish) begin
            r_level   <= w_lvl[LEVEL_W-1:0];
            r_ramp_en <= r_start != r_end;
        end
    end

    assign o_sts.sat      = r_sat;
    assign o_level        = r_level;
    assign o_ramp_enabled = r_ramp_en;

endmodule

### design/timed_linear_ramp_generator_unit.sv
// Top level of the timed linear ramp generator: controller plus datapath.
//
//  channel   direction  payload
//  s_*       in         tdata[31:0] now_time
//  m_*       out        tdata[7:0] level, [8] ramp_enabled, [15:9] zero
//  cfg_*     in         addr 0 start, 1 end, 2 duration, 3 start time, 4 blink
//
// After acceptance the steps PREP, DIV, SCALE, RECIP and DONE present the result
// (seven restoring-divide steps in DIV on elapsed*100 / duration); once the
// elapsed time reaches the duration, the divide steps are skipped. One timestamp
// is taken at a time, as the input reopens when the result is presented.
// A result left waiting on m_tready holds the machine only at its last step.
// Reset is synchronous, active low: levels 0, duration 1, origin 0, forward.
module timed_linear_ramp_generator_unit
    import tlrg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input timestamps
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TIME_W-1:0]     i_s_tdata,     // [31:0] now_time
    // output levels
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [15:0]           o_m_tdata,     // [7:0] level, [8] ramp_enabled
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [LEVEL_W-1:0] w_level;
    logic               w_ramp_en;

    // sequence the transaction
    tlrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // hold configuration and compute the level
    tlrg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_now_time     (i_s_tdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_level        (w_level),
        .o_ramp_enabled (w_ramp_en)
    );

    // pad the result to whole bytes
    assign o_m_tdata = {7'd0, w_ramp_en, w_level};

endmodule

### design/tlrg_checker.sv
// Port-level checker for the ramp generator, bound to the top level.
`include "assert_macros.svh"

module tlrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // one timestamp in flight at a time
    `ASSERT_CLK_RST(a_one_in_flight, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> !o_s_tready, "accepted twice in a row")
    // a new result appears only at the end of a busy period
    `ASSERT_CLK_RST(a_result_after_busy, i_clk, i_rst_n, ($rose(o_m_tvalid) && $past(i_rst_n)) |-> $past(!o_s_tready), "result without work")
    // the input reopens exactly when a result is issued
    `ASSERT_CLK_RST(a_ready_with_result, i_clk, i_rst_n, ($rose(o_s_tready) && $past(i_rst_n)) |-> o_m_tvalid, "ready without result")
    // a stalled result holds
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled result changed")
    // reset leaves the block ready and empty
    `ASSERT_CLK(a_reset_state, i_clk, !i_rst_n |=> (o_s_tready && !o_m_tvalid), "bad state after reset")

endmodule

bind timed_linear_ramp_generator_unit tlrg_checker u_tlrg_checker (.*);
